[rtl/core/kmhr_pkg.sv]
// Shared types, usage-code constants and keymap ROM for the key matrix
// HID report builder. No dependencies; imported by the top, kmhr_ctrl and kmhr_dp.
`default_nettype none

package kmhr_pkg;

  // HID usage codes with special meaning
  localparam logic [7:0] CODE_LAYER  = 8'hFF;
  localparam logic [7:0] CODE_MOD_LO = 8'hE0;
  localparam logic [7:0] CODE_MOD_HI = 8'hE7;
  localparam logic [7:0] CODE_EMPTY  = 8'h00;

  // Fixed keymap size
  localparam int ROM_ROWS = 5;
  localparam int ROM_COLS = 13;

  // Number of keycode fields in a report
  localparam int REPORT_SLOTS = 6;

  typedef logic [7:0] code_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the sample and its keycode
    logic apply;    // update bitmaps, modifiers, slots and layer
    logic emit;     // load the output register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_end;  // latched sample ends a scan
    logic report;    // some row is non-zero or changed after this sample
    logic out_free;  // output register can take a report this cycle
  } dp_sts_t;

  localparam code_t ROM_LAYER0 [ROM_ROWS][ROM_COLS] = '{
    '{8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E},
    '{8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30},
    '{8'h39, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h31},
    '{8'hE1, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'hE5, 8'h35},
    '{8'hE3, 8'hFE, 8'hFF, 8'hE2, 8'h2A, 8'h28, 8'h2C, 8'h8A, 8'hE4, 8'h50, 8'h51, 8'h52, 8'h4F}
  };

  localparam code_t ROM_LAYER1 [ROM_ROWS][ROM_COLS] = '{
    '{8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2F, 8'h30},
    '{8'h2B, 8'h34, 8'h36, 8'h12, 8'h18, 8'h1C, 8'h09, 8'h0A, 8'h06, 8'h15, 8'h0F, 8'h38, 8'h2E},
    '{8'hE0, 8'h13, 8'h0C, 8'h08, 8'h04, 8'h37, 8'h07, 8'h16, 8'h17, 8'h0B, 8'h1D, 8'h2D, 8'h31},
    '{8'hE1, 8'h0D, 8'h14, 8'h33, 8'h0E, 8'h1B, 8'h05, 8'h10, 8'h1A, 8'h11, 8'h19, 8'hE5, 8'h35},
    '{8'hE3, 8'hFE, 8'hFF, 8'hE2, 8'h2A, 8'h4C, 8'h28, 8'h2C, 8'h39, 8'h50, 8'h51, 8'h52, 8'h4F}
  };

  // Look up a key position; positions outside the keymap read as empty
  function automatic code_t keymap_code(input logic layer, input logic [2:0] row,
                                        input logic [3:0] column);
    code_t code;
    code = CODE_EMPTY;
    if ((row < 3'(ROM_ROWS)) && (column < 4'(ROM_COLS))) begin
      code = layer ? ROM_LAYER1[row][column] : ROM_LAYER0[row][column];
    end
    return code;
  endfunction

endpackage

`default_nettype wire

[rtl/core/key_matrix_hid_report_builder.sv]
// Top level of the key matrix HID report builder.
// Depends on kmhr_pkg, kmhr_ctrl and kmhr_dp.
`default_nettype none

// Turns scanned key samples into reports of a modifier byte, six keycode
// slots and the active layer bit. Each sample is first latched and its
// keycode read from the keymap ROM, then the row bitmaps, modifiers, slots
// and layer are updated; in_stall is high during the update. A scan-end
// sample that yields a report then loads the output register, waiting
// while a previous report is still stalled at the output. A finished report
// waits in the output register while the next samples are taken.
module key_matrix_hid_report_builder #(
  parameter int ROWS    = 5,
  parameter int COLUMNS = 13,
  parameter int SLOTS   = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] row,
  input  logic [3:0] column,
  input  logic       pressed,
  input  logic       scan_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] modifier_bits,
  output logic [7:0] slot_zero,
  output logic [7:0] slot_one,
  output logic [7:0] slot_two,
  output logic [7:0] slot_three,
  output logic [7:0] slot_four,
  output logic [7:0] slot_five,
  output logic       layer_now
);
  import kmhr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  kmhr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kmhr_dp #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS),
    .SLOTS   (SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .row           (row),
    .column        (column),
    .pressed       (pressed),
    .scan_end      (scan_end),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .modifier_bits (modifier_bits),
    .slot_zero     (slot_zero),
    .slot_one      (slot_one),
    .slot_two      (slot_two),
    .slot_three    (slot_three),
    .slot_four     (slot_four),
    .slot_five     (slot_five),
    .layer_now     (layer_now)
  );

endmodule

`default_nettype wire

[rtl/core/kmhr_ctrl.sv]
// Sequencer for the key matrix HID report builder: capture, apply, emit.
// Depends on kmhr_pkg for the command and status structs.
`default_nettype none

module kmhr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  kmhr_pkg::dp_sts_t sts,
  output kmhr_pkg::dp_cmd_t cmd
);
  import kmhr_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_APPLY = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Take a sample only when idle
  assign in_stall = (state != S_IDLE);

  // Issue commands and pick next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (sts.scan_end && sts.report) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        // Hold until the output register frees up
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/kmhr_dp.sv]
// Datapath of the key matrix HID report builder: row bitmaps, modifier byte,
// keycode slots, layer select and the report output register. Uses kmhr_pkg.
`default_nettype none

module kmhr_dp #(
  parameter int ROWS    = 5,
  parameter int COLUMNS = 13,
  parameter int SLOTS   = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  kmhr_pkg::dp_cmd_t cmd,
  output kmhr_pkg::dp_sts_t sts,
  input  logic [2:0]        row,
  input  logic [3:0]        column,
  input  logic              pressed,
  input  logic              scan_end,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        modifier_bits,
  output logic [7:0]        slot_zero,
  output logic [7:0]        slot_one,
  output logic [7:0]        slot_two,
  output logic [7:0]        slot_three,
  output logic [7:0]        slot_four,
  output logic [7:0]        slot_five,
  output logic              layer_now
);
  import kmhr_pkg::*;

  // Latched sample
  logic [2:0] row_q;
  logic [3:0] column_q;
  logic       pressed_q;
  logic       scan_end_q;
  code_t      code_q;

  // Report state
  logic [COLUMNS-1:0] row_now    [ROWS];
  logic [COLUMNS-1:0] row_before [ROWS];
  logic [7:0]         modifier_reg;
  code_t              code_slots [SLOTS];
  logic               layer_sel;
  logic               toggle_latched;

  // Next values
  logic [COLUMNS-1:0] row_now_next [ROWS];
  code_t              code_slots_next [SLOTS];
  logic [7:0]         modifier_next;
  logic               layer_next;
  logic               toggle_next;

  // Decode
  logic               in_range;
  logic [COLUMNS-1:0] col_mask;
  logic [ROWS-1:0]    row_hit;
  logic [ROWS-1:0]    row_diff;
  logic [ROWS-1:0]    row_active;
  logic               sel_changed;
  logic               do_press;
  logic               do_release;
  logic               is_layer;
  logic               is_mod;
  logic [7:0]         mod_mask;
  logic               slot_found;

  // Output register
  code_t              slot_view [REPORT_SLOTS];
  code_t              out_slot  [REPORT_SLOTS];

  // Decode sample position
  always_comb begin
    in_range = ({2'b00, row_q} < 5'(ROWS)) && ({1'b0, column_q} < 5'(COLUMNS));
    for (int j = 0; j < COLUMNS; j++) begin
      col_mask[j] = (column_q == 4'(j));
    end
  end

  // Update each row bitmap and flag rows that differ from the last scan
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      row_hit[i] = in_range && ({2'b00, row_q} == 5'(i));
      if (row_hit[i]) begin
        row_now_next[i] = pressed_q ? (row_now[i] | col_mask) : (row_now[i] & ~col_mask);
      end else begin
        row_now_next[i] = row_now[i];
      end
      row_diff[i]   = (row_now_next[i] != row_before[i]);
      row_active[i] = row_diff[i] || (|row_now_next[i]);
    end
    sel_changed = |(row_hit & row_diff);
  end

  // Classify the keycode; a release counts only if its row differs from the last scan
  always_comb begin
    do_press   = in_range && pressed_q;
    do_release = in_range && !pressed_q && sel_changed;
    is_layer   = (code_q == CODE_LAYER);
    is_mod     = code_q inside {[CODE_MOD_LO:CODE_MOD_HI]};
    mod_mask   = 8'd1 << code_q[2:0];
  end

  // Modifier, layer and slot updates
  always_comb begin
    modifier_next   = modifier_reg;
    layer_next      = layer_sel;
    toggle_next     = toggle_latched;
    code_slots_next = code_slots;
    slot_found      = 1'b0;
    if (do_press) begin
      if (is_layer) begin
        if (!toggle_latched) begin
          layer_next  = ~layer_sel;
          toggle_next = 1'b1;
        end
      end else if (is_mod) begin
        modifier_next = modifier_reg | mod_mask;
      end else begin
        // Stop at a held copy or fill the first empty slot
        for (int k = 0; k < SLOTS; k++) begin
          if (!slot_found) begin
            if (code_slots[k] == code_q) begin
              slot_found = 1'b1;
            end else if (code_slots[k] == CODE_EMPTY) begin
              code_slots_next[k] = code_q;
              slot_found         = 1'b1;
            end
          end
        end
      end
    end else if (do_release) begin
      if (is_layer) begin
        toggle_next = 1'b0;
      end else if (is_mod) begin
        modifier_next = modifier_reg & ~mod_mask;
      end else begin
        // Drop the code from every slot that holds it
        for (int k = 0; k < SLOTS; k++) begin
          if (code_slots[k] == code_q) begin
            code_slots_next[k] = CODE_EMPTY;
          end
        end
      end
    end
  end

  // Status to controller
  always_comb begin
    sts.scan_end = scan_end_q;
    sts.report   = |row_active;
    sts.out_free = !out_valid || !out_stall;
  end

  // Report view of the slots; missing slots read as empty
  for (genvar g = 0; g < REPORT_SLOTS; g++) begin : g_view
    if (g < SLOTS) begin : g_have
      assign slot_view[g] = code_slots[g];
    end else begin : g_none
      assign slot_view[g] = CODE_EMPTY;
    end
  end

  // Capture sample and look up its keycode for the active layer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_q      <= row;
      column_q   <= column;
      pressed_q  <= pressed;
      scan_end_q <= scan_end;
      code_q     <= keymap_code(layer_sel, row, column);
    end
  end

  // Advance report state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS; i++) begin
        row_now[i]    <= '0;
        row_before[i] <= '0;
      end
      for (int k = 0; k < SLOTS; k++) begin
        code_slots[k] <= CODE_EMPTY;
      end
      modifier_reg   <= '0;
      layer_sel      <= 1'b0;
      toggle_latched <= 1'b0;
    end else if (cmd.apply) begin
      for (int i = 0; i < ROWS; i++) begin
        row_now[i] <= row_now_next[i];
        if (scan_end_q) begin
          row_before[i] <= row_now_next[i];
        end
      end
      code_slots     <= code_slots_next;
      modifier_reg   <= modifier_next;
      layer_sel      <= layer_next;
      toggle_latched <= toggle_next;
    end
  end

  // Output valid: set on emit, drop when the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      modifier_bits <= modifier_reg;
      out_slot      <= slot_view;
      layer_now     <= layer_sel;
    end
  end

  assign slot_zero  = out_slot[0];
  assign slot_one   = out_slot[1];
  assign slot_two   = out_slot[2];
  assign slot_three = out_slot[3];
  assign slot_four  = out_slot[4];
  assign slot_five  = out_slot[5];

endmodule

`default_nettype wire

[rtl/core/kmhr_chk.sv]
// Port-level checker for the key matrix HID report builder, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module kmhr_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       scan_end,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] modifier_bits,
  input logic [7:0] slot_zero,
  input logic [7:0] slot_five,
  input logic       layer_now
);

  // Hold a stalled report
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(modifier_bits)
      && $stable(slot_zero) && $stable(slot_five) && $stable(layer_now))
    else $error("stalled report changed or dropped");

  // Stall the input for the update cycle after each transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken during update cycle");

  // A new report follows a scan-end transaction
  a_report_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && scan_end, 3))
    else $error("report without scan-end sample");

  // Clear output valid out of reset
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind key_matrix_hid_report_builder kmhr_chk u_kmhr_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .scan_end      (scan_end),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .modifier_bits (modifier_bits),
  .slot_zero     (slot_zero),
  .slot_five     (slot_five),
  .layer_now     (layer_now)
);

`default_nettype wire
